/* sv/heart_rate_interval_averager_unit_defines.svh */
// Assertion helpers for the heart-rate averager unit.
// Each macro expects signals named clk and rst_n in the using module.
`ifndef HEART_RATE_INTERVAL_AVERAGER_UNIT_DEFINES_SVH
`define HEART_RATE_INTERVAL_AVERAGER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define HRIA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define HRIA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/hria_pkg.sv */
`timescale 1ns / 1ps
package hria_pkg;

  // Field widths.
  localparam int LEVEL_W = 18;
  localparam int TIME_W  = 32;
  localparam int RATE_W  = 8;

  // Ring depth default.
  localparam int HISTORY_DEPTH_DEF = 10;

  // Constants of the rate computation.
  localparam logic [RATE_W-1:0] RESET_RATE      = 8'd60;
  localparam logic [LEVEL_W-1:0] THRESHOLD_RESET = 18'd50000;
  localparam logic [TIME_W-1:0] MIN_INTERVAL    = 32'd236;
  localparam logic [TIME_W-1:0] MAX_INTERVAL    = 32'd2999;

  // Serial divider sizing: the quotient always fits in eight bits.
  localparam int DIVIDEND_W = 16;
  localparam int DIVISOR_W  = 12;
  localparam int QUOT_W     = 8;
  localparam int SHD_W      = DIVISOR_W + QUOT_W - 1;
  localparam int CMP_W      = (SHD_W > DIVIDEND_W) ? SHD_W : DIVIDEND_W;
  localparam int STEP_W     = $clog2(QUOT_W);

  localparam logic [DIVIDEND_W-1:0] MS_PER_MINUTE = 16'd60000;

  // Request into the divider.
  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  // Response from the divider.
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* sv/heart_rate_interval_averager_unit.sv */
`timescale 1ns / 1ps
// Heart-rate beat-interval averager.
// Input channel (in_): one request per optical sample, carrying the infrared
// level and timestamp in in_tdata and the beat flag in in_tuser.
// Output channel (out_): exactly one request per input, carrying the running
// average rate in out_tdata and the accepted and finger-absent flags in out_tuser.
// cfg_wr_en writes the presence threshold from cfg_wr_data; write only when idle.
// Items are processed one at a time. A sample with no finger, no beat or an
// implausible interval goes from acceptance straight to the hold state, which
// loads the output register and returns to idle for the next request. A stored
// beat passes through the serial divider for 60000/interval, whose quotient is
// collected as the rate, then the summing state, in which the ring rotates one
// cell per cycle past the summing adder, then one step that forms the mean by a
// reciprocal multiply, and last the hold state that loads the output.
// The result sits in an output register; the next input is accepted while it
// waits, and a finished result that finds the register still full is held
// until the receiver takes the previous one.
// Reset clears the control state, fills every cell with 60, zeroes the last
// beat time and sets the threshold to 50000. No clearing pass is needed.
`include "heart_rate_interval_averager_unit_defines.svh"
module heart_rate_interval_averager_unit #(
  parameter int HISTORY_DEPTH = hria_pkg::HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input requests.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // [17:0] ir_level, [49:18] time_ms, rest zero
  input  logic        in_tuser,   // [0] beat_seen
  // Result requests.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] average_rate
  output logic [1:0]  out_tuser,  // [0] rate_accepted, [1] finger_absent
  // Threshold register.
  input  logic        cfg_wr_en,
  input  logic [17:0] cfg_wr_data
);

  localparam int SUM_W = $clog2(255 * HISTORY_DEPTH + 1);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

  // Mean by reciprocal multiply, exact for every sum of the ring.
  localparam int AVG_SHIFT = SUM_W + $clog2(HISTORY_DEPTH);
  localparam int AVG_MUL_W = AVG_SHIFT + 1;
  localparam int PROD_W    = SUM_W + AVG_MUL_W;
  localparam logic [AVG_MUL_W-1:0] AVG_MUL =
    AVG_MUL_W'(((1 << AVG_SHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RATE_DIV,
    ST_SUM,
    ST_ROTATE,
    ST_HOLD
  } state_t;

  state_t                       state_r, state_nxt;
  logic [hria_pkg::LEVEL_W-1:0] thresh_r;
  logic [hria_pkg::TIME_W-1:0]  prev_time_r, prev_time_nxt;
  logic [hria_pkg::RATE_W-1:0]  avg_r, avg_nxt;
  logic [hria_pkg::RATE_W-1:0]  rate_r, rate_nxt;
  logic [SUM_W-1:0]             sum_r, sum_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         res_acc_r, res_acc_nxt;
  logic                         res_abs_r, res_abs_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [hria_pkg::RATE_W-1:0]  out_avg_r, out_avg_nxt;
  logic                         out_acc_r, out_acc_nxt;
  logic                         out_abs_r, out_abs_nxt;

  logic [hria_pkg::LEVEL_W-1:0] in_level;
  logic [hria_pkg::TIME_W-1:0]  in_time;
  logic [hria_pkg::TIME_W-1:0]  interval;
  logic                         in_fire;
  logic                         absent;
  logic                         in_range;

  logic                         fill_en;
  logic                         ring_fill;
  logic                         shift_en;
  logic [hria_pkg::RATE_W-1:0]  ring_in;
  logic [hria_pkg::RATE_W-1:0]  cell_q [HISTORY_DEPTH];
  logic [hria_pkg::RATE_W-1:0]  sum_val;
  logic [PROD_W-1:0]            avg_prod;

  hria_pkg::div_req_t           div_req;
  hria_pkg::div_rsp_t           div_rsp;

  // Input field decode and range check of the beat interval.
  assign in_level  = in_tdata[17:0];
  assign in_time   = in_tdata[49:18];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign absent    = (in_level < thresh_r);
  assign interval  = in_time - prev_time_r;
  assign in_range  = (interval >= hria_pkg::MIN_INTERVAL) &&
                     (interval <= hria_pkg::MAX_INTERVAL);

  // The first summing step uses the new rate in place of the head cell.
  assign sum_val = (cnt_r == '0) ? rate_r : cell_q[0];

  // Sum of the ring times the reciprocal of the depth.
  assign avg_prod = PROD_W'(sum_r) * PROD_W'(AVG_MUL);

  // Ring of cells; cell zero is the slot the next rate overwrites.
  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    logic [hria_pkg::RATE_W-1:0] din;
    if (g == HISTORY_DEPTH - 1) begin : g_tail
      assign din = ring_in;
    end else begin : g_body
      assign din = cell_q[g+1];
    end
    hria_cell u_cell (
      .clk      (clk),
      .fill_en  (ring_fill),
      .shift_en (shift_en),
      .din      (din),
      .dout     (cell_q[g])
    );
  end

  hria_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    prev_time_nxt = prev_time_r;
    avg_nxt       = avg_r;
    rate_nxt      = rate_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    res_acc_nxt   = res_acc_r;
    res_abs_nxt   = res_abs_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_avg_nxt   = out_avg_r;
    out_acc_nxt   = out_acc_r;
    out_abs_nxt   = out_abs_r;
    fill_en       = 1'b0;
    shift_en      = 1'b0;
    ring_in       = cell_q[0];
    div_req       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          res_acc_nxt = 1'b0;
          res_abs_nxt = absent;
          state_nxt   = ST_HOLD;
          if (absent) begin
            fill_en = 1'b1;
            avg_nxt = hria_pkg::RESET_RATE;
          end else if (in_tuser) begin
            prev_time_nxt = in_time;
            if (in_range) begin
              res_acc_nxt      = 1'b1;
              div_req.start    = 1'b1;
              div_req.dividend = hria_pkg::MS_PER_MINUTE;
              div_req.divisor  = interval[hria_pkg::DIVISOR_W-1:0];
              state_nxt        = ST_RATE_DIV;
            end
          end
        end
      end
      ST_RATE_DIV: begin
        if (div_rsp.done) begin
          rate_nxt  = div_rsp.quotient;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        shift_en = 1'b1;
        ring_in  = sum_val;
        sum_nxt  = sum_r + SUM_W'(sum_val);
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(HISTORY_DEPTH - 1)) begin
          state_nxt = ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        // Step past the new rate so the head is the next slot to write,
        // and take the mean of the finished sum.
        shift_en  = 1'b1;
        avg_nxt   = avg_prod[AVG_SHIFT +: hria_pkg::RATE_W];
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = avg_r;
          out_acc_nxt   = res_acc_r;
          out_abs_nxt   = res_abs_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thresh_r    <= hria_pkg::THRESHOLD_RESET;
      prev_time_r <= '0;
      avg_r       <= hria_pkg::RESET_RATE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_time_r <= prev_time_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        thresh_r <= cfg_wr_data;
      end
    end
    rate_r    <= rate_nxt;
    sum_r     <= sum_nxt;
    cnt_r     <= cnt_nxt;
    res_acc_r <= res_acc_nxt;
    res_abs_r <= res_abs_nxt;
    out_avg_r <= out_avg_nxt;
    out_acc_r <= out_acc_nxt;
    out_abs_r <= out_abs_nxt;
  end

  // Reset of the ring is the same fill that a missing finger causes.
  assign ring_fill = fill_en || !rst_n;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_avg_r;
  assign out_tuser  = {out_abs_r, out_acc_r};

  `HRIA_ASSERT_NOW(a_flags_exclusive, out_tvalid, !(out_tuser[0] && out_tuser[1]), "flags clash")
  `HRIA_ASSERT_NEXT(a_accept_leaves_idle, in_fire, state_r != ST_IDLE, "idle after request")
  `HRIA_ASSERT_NOW(a_div_done_expected, div_rsp.done, state_r == ST_RATE_DIV, "stray done")

endmodule

/* sv/hria_cell.sv */
`timescale 1ns / 1ps
// One ring cell: holds a stored rate and passes it to its neighbor on a shift.
module hria_cell (
  input  logic                       clk,
  input  logic                       fill_en,
  input  logic                       shift_en,
  input  logic [hria_pkg::RATE_W-1:0] din,
  output logic [hria_pkg::RATE_W-1:0] dout
);

  logic [hria_pkg::RATE_W-1:0] val_r;
  logic [hria_pkg::RATE_W-1:0] val_nxt;

  // Fill wins over shift; the value is otherwise held.
  always_comb begin
    val_nxt = val_r;
    if (fill_en) begin
      val_nxt = hria_pkg::RESET_RATE;
    end else if (shift_en) begin
      val_nxt = din;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign dout = val_r;

endmodule

/* sv/hria_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, for quotients below 256.
module hria_div (
  input  logic               clk,
  input  logic               rst_n,
  input  hria_pkg::div_req_t req,
  output hria_pkg::div_rsp_t rsp
);

  logic                            busy_r;
  logic                            done_r;
  logic [hria_pkg::STEP_W-1:0]     step_r;
  logic [hria_pkg::DIVIDEND_W-1:0] rem_r;
  logic [hria_pkg::SHD_W-1:0]      shd_r;
  logic [hria_pkg::QUOT_W-1:0]     quot_r;
  logic [hria_pkg::CMP_W-1:0]      rem_ext;
  logic [hria_pkg::CMP_W-1:0]      shd_ext;
  logic [hria_pkg::CMP_W-1:0]      diff;
  logic                            ge;

  // Trial subtraction of the shifted divisor.
  always_comb begin
    rem_ext = hria_pkg::CMP_W'(rem_r);
    shd_ext = hria_pkg::CMP_W'(shd_r);
    diff    = rem_ext - shd_ext;
    ge      = (rem_ext >= shd_ext);
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == hria_pkg::STEP_W'(hria_pkg::QUOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.dividend;
      shd_r  <= {req.divisor, {(hria_pkg::QUOT_W-1){1'b0}}};
      quot_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= diff[hria_pkg::DIVIDEND_W-1:0];
      end
      shd_r  <= shd_r >> 1;
      quot_r <= {quot_r[hria_pkg::QUOT_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quot_r;

endmodule

/* tb/heart_rate_interval_averager_unit_tb.sv */
`timescale 1ns / 1ps
module heart_rate_interval_averager_unit_tb;

  localparam int DEPTH       = hria_pkg::HISTORY_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;

  // One sample request as the sender sees it.
  typedef struct packed {
    logic [hria_pkg::LEVEL_W-1:0] level;
    logic                         beat;
    logic [hria_pkg::TIME_W-1:0]  stamp;
    logic                         fixed;     // expectation typed into the row
    logic [hria_pkg::RATE_W-1:0]  fix_avg;
    logic                         fix_acc;
    logic                         fix_abs;
  } sample_row_t;

  // One result as it leaves the block.
  typedef struct packed {
    logic [hria_pkg::RATE_W-1:0] avg;
    logic                        accepted;
    logic                        absent;
  } bpm_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en;
  logic [17:0] cfg_wr_data;

  // Predictor state: ring of rates, write slot, last beat time, average, threshold.
  logic [hria_pkg::RATE_W-1:0]  rate_ring [DEPTH];
  int                           ring_slot;
  logic [hria_pkg::TIME_W-1:0]  last_beat_ms;
  logic [hria_pkg::RATE_W-1:0]  avg_bpm;
  logic [hria_pkg::LEVEL_W-1:0] threshold_lvl;

  bpm_result_t pending_results [$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  logic        calm_stretch = 1'b0;

  // Directed samples; the reset threshold applies.
  sample_row_t directed_rows [0:12] = '{
    // Finger absent right after reset.
    '{18'd0,       1'b0, 32'd0,          1'b1, hria_pkg::RESET_RATE, 1'b0, 1'b1},
    // Full level, no beat.
    '{18'h3FFFF,   1'b0, 32'd0,          1'b1, hria_pkg::RESET_RATE, 1'b0, 1'b0},
    // Level exactly at threshold, beat with zero interval.
    '{18'd50000,   1'b1, 32'd0,          1'b1, hria_pkg::RESET_RATE, 1'b0, 1'b0},
    // Interval one below the shortest accepted.
    '{18'h3FFFF,   1'b1, 32'd235,        1'b1, hria_pkg::RESET_RATE, 1'b0, 1'b0},
    // Shortest accepted interval, then the longest.
    '{18'h3FFFF,   1'b1, 32'd471,        1'b0, 8'd0, 1'b0, 1'b0},
    '{18'h3FFFF,   1'b1, 32'd3470,       1'b0, 8'd0, 1'b0, 1'b0},
    // One past the longest accepted interval.
    '{18'h3FFFF,   1'b1, 32'd6470,       1'b0, 8'd0, 1'b0, 1'b0},
    // Time wraps between these two beats.
    '{18'd123456,  1'b1, 32'hFFFFFF00,   1'b0, 8'd0, 1'b0, 1'b0},
    '{18'd200000,  1'b1, 32'h000002FF,   1'b0, 8'd0, 1'b0, 1'b0},
    // Level one below threshold with a beat: history cleared, beat ignored.
    '{18'd49999,   1'b1, 32'h00000500,   1'b1, hria_pkg::RESET_RATE, 1'b0, 1'b1},
    '{18'd50000,   1'b1, 32'h000006E7,   1'b0, 8'd0, 1'b0, 1'b0},
    '{18'h2AAAA,   1'b1, 32'hFFFFFFFF,   1'b0, 8'd0, 1'b0, 1'b0},
    // Finger present, no beat, ring still all 60.
    '{18'h15555,   1'b0, 32'hFFFFFFFF,   1'b1, hria_pkg::RESET_RATE, 1'b0, 1'b0}
  };

  heart_rate_interval_averager_unit #(
    .HISTORY_DEPTH(DEPTH)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the result of one accepted sample and advances the predictor.
  function automatic bpm_result_t predict_sample(logic [hria_pkg::LEVEL_W-1:0] level,
                                                 logic beat,
                                                 logic [hria_pkg::TIME_W-1:0] stamp);
    bpm_result_t res;
    logic [hria_pkg::TIME_W-1:0] gap;
    int sum;
    res = '0;
    if (level < threshold_lvl) begin
      for (int k = 0; k < DEPTH; k++) rate_ring[k] = hria_pkg::RESET_RATE;
      avg_bpm = hria_pkg::RESET_RATE;
      res.absent = 1'b1;
    end else if (beat) begin
      gap = stamp - last_beat_ms;
      last_beat_ms = stamp;
      if (gap >= hria_pkg::MIN_INTERVAL && gap <= hria_pkg::MAX_INTERVAL) begin
        rate_ring[ring_slot] = hria_pkg::RATE_W'({16'd0, hria_pkg::MS_PER_MINUTE} / gap);
        ring_slot = (ring_slot == DEPTH - 1) ? 0 : ring_slot + 1;
        sum = 0;
        for (int k = 0; k < DEPTH; k++) sum += rate_ring[k];
        avg_bpm = hria_pkg::RATE_W'(sum / DEPTH);
        res.accepted = 1'b1;
      end
    end
    res.avg = avg_bpm;
    return res;
  endfunction

  // Offers one sample, waits for the handshake and records what should come back.
  task automatic send_sample(sample_row_t row);
    bpm_result_t want;
    while (!calm_stretch && $urandom_range(0, 99) < 13) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'd0, row.stamp, row.level};
    in_tuser  <= row.beat;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    want = predict_sample(row.level, row.beat, row.stamp);
    if (row.fixed) want = '{row.fix_avg, row.fix_acc, row.fix_abs};
    pending_results.push_back(want);
  endtask

  // Lets the block drain, then writes a new presence threshold.
  task automatic set_presence_threshold(logic [hria_pkg::LEVEL_W-1:0] value);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold_lvl = value;
  endtask

  // A run of random samples, mostly plausible beat trains.
  task automatic random_samples(int count);
    sample_row_t row;
    int pick;
    for (int n = 0; n < count; n++) begin
      row = '0;
      pick = $urandom_range(0, 99);
      row.level = hria_pkg::LEVEL_W'($urandom_range(18'h3FFFF, threshold_lvl));
      if (pick < 70) begin
        row.beat = ($urandom_range(0, 9) < 6);
        row.stamp = last_beat_ms + (row.beat ? $urandom_range(236, 2999)
                                             : $urandom_range(0, 3500));
      end else if (pick < 80) begin
        // Intervals on and around the acceptance bounds.
        row.beat = 1'b1;
        case ($urandom_range(0, 5))
          0: row.stamp = last_beat_ms;
          1: row.stamp = last_beat_ms + hria_pkg::MIN_INTERVAL - 1;
          2: row.stamp = last_beat_ms + hria_pkg::MIN_INTERVAL;
          3: row.stamp = last_beat_ms + hria_pkg::MAX_INTERVAL;
          4: row.stamp = last_beat_ms + hria_pkg::MAX_INTERVAL + 1;
          default: row.stamp = $urandom;
        endcase
      end else if (pick < 90) begin
        if (threshold_lvl != 0) begin
          row.level = hria_pkg::LEVEL_W'($urandom_range(threshold_lvl - 1, 0));
        end
        row.beat = 1'($urandom_range(0, 1));
        row.stamp = $urandom;
      end else begin
        row.level = hria_pkg::LEVEL_W'($urandom);
        row.beat = 1'($urandom_range(0, 1));
        row.stamp = $urandom;
      end
      send_sample(row);
    end
  endtask

  // Receiver: random stalls and comparison against the oldest expectation.
  always @(posedge clk) begin : result_check
    bpm_result_t want;
    out_tready <= calm_stretch || ($urandom_range(0, 99) >= 13);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: average_rate %0d", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.avg) begin
          $error("average_rate: expected %0d, got %0d", want.avg, out_tdata);
          mismatch_count++;
        end
        if (out_tuser[0] !== want.accepted) begin
          $error("rate_accepted: expected %0d, got %0d", want.accepted, out_tuser[0]);
          mismatch_count++;
        end
        if (out_tuser[1] !== want.absent) begin
          $error("finger_absent: expected %0d, got %0d", want.absent, out_tuser[1]);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("heart_rate_interval_averager_unit_tb NOT OK");
    $finish;
  end

  // Main sequence: reset, directed rows, then random phases at several thresholds.
  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= 1'b0;
    out_tready  <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    for (int k = 0; k < DEPTH; k++) rate_ring[k] = hria_pkg::RESET_RATE;
    ring_slot     = 0;
    last_beat_ms  = '0;
    avg_bpm       = hria_pkg::RESET_RATE;
    threshold_lvl = hria_pkg::THRESHOLD_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_sample(directed_rows[i]);
    random_samples(400);

    // No finger can be absent; this phase also runs without any stalls.
    set_presence_threshold(18'd0);
    calm_stretch = 1'b1;
    random_samples(300);
    calm_stretch = 1'b0;

    set_presence_threshold(18'h3FFFF);
    random_samples(150);
    set_presence_threshold(18'd1);
    random_samples(250);
    set_presence_threshold(hria_pkg::LEVEL_W'($urandom));
    random_samples(300);
    set_presence_threshold(hria_pkg::THRESHOLD_RESET);
    random_samples(400);

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("heart_rate_interval_averager_unit_tb OK");
    end else begin
      $display("heart_rate_interval_averager_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/hria_pkg.sv
sv/hria_cell.sv
sv/hria_div.sv
sv/heart_rate_interval_averager_unit.sv
tb/heart_rate_interval_averager_unit_tb.sv
